@@ hw/rtl/qcs_pkg.sv @@
// ----------------------------------------------------------------------------
// qcs_pkg
// Shared types, operation codes and status codes for the circular queue.
// ----------------------------------------------------------------------------
package qcs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 3;

  typedef logic        [OP_W-1:0]   op_t;
  typedef logic        [STAT_W-1:0] status_t;
  typedef logic signed [DATA_W-1:0] word_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  localparam status_t ST_DONE      = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  // per-cell control: rotate the ring by one, or load the insert word
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/qcs_if.sv @@
// ----------------------------------------------------------------------------
// qcs_if
// Valid/ready channels for queue requests and queue responses.
// ----------------------------------------------------------------------------
interface qcs_req_if;
  logic             valid;
  logic             ready;
  qcs_pkg::op_t     op;
  qcs_pkg::word_t   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface qcs_rsp_if;
  logic             valid;
  logic             ready;
  qcs_pkg::status_t status;
  qcs_pkg::word_t   removed_value;

  modport source (output valid, output status, output removed_value, input ready);
  modport sink   (input valid, input status, input removed_value, output ready);
endinterface

@@ hw/rtl/qcs_cell.sv @@
// ----------------------------------------------------------------------------
// qcs_cell
// One storage cell of the queue ring: holds a word, takes its neighbor's
// word on a shift, or the insert word on a load.
// ----------------------------------------------------------------------------
module qcs_cell (
  input  logic                clk,
  input  qcs_pkg::cell_ctrl_t ctrl,
  input  qcs_pkg::word_t      load_data,
  input  qcs_pkg::word_t      nbr_data,
  output qcs_pkg::word_t      data
);

  qcs_pkg::word_t data_next;

  always_comb begin
    data_next = data;
    if (ctrl.load) begin
      data_next = load_data;
    end else if (ctrl.shift) begin
      data_next = nbr_data;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ hw/rtl/circular_queue_with_search_core.sv @@
// ----------------------------------------------------------------------------
// circular_queue_with_search_core
// Fixed-depth FIFO of signed words built as a ring of cells, oldest entry
// in cell 0 whenever no search is running, with insert, delete and a linear search.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------
//  req     | in  | valid / ready | op[1:0], value[31:0]
//  rsp     | out | valid / ready | status[2:0], removed_value[31:0]
//
//  insert, delete, no-op and search of an empty queue: response registered
//  in the cycle after the transaction
//  search of a non-empty queue: the ring rotates once through the single
//  comparator on cell 0 and ends in its original order
//  reset clears the occupancy count and control; cell contents stay undefined
//  a stalled response holds; a new request is taken once no search runs and
//  the response register is empty or being drained in the same cycle
// ----------------------------------------------------------------------------
module circular_queue_with_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  qcs_req_if.sink          req,
  qcs_rsp_if.source        rsp
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state;
  logic [OCC_W-1:0]    occupancy;
  logic [IDX_W-1:0]    scan_cnt;
  logic                found;
  qcs_pkg::word_t      key;

  logic                rsp_valid;
  qcs_pkg::status_t    rsp_status;
  qcs_pkg::word_t      rsp_removed;

  qcs_pkg::word_t      cell_q [DEPTH];

  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic                ins_fire;
  logic                del_fire;
  logic                scan_start;
  logic                rotate;
  logic                scan_last;
  logic                hit;
  qcs_pkg::status_t    acc_status;
  qcs_pkg::word_t      acc_removed;

  assign req.ready         = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.removed_value = rsp_removed;

  assign accept     = req.valid && req.ready;
  assign is_full    = (occupancy == OCC_W'(DEPTH));
  assign is_empty   = (occupancy == '0);
  assign ins_fire   = accept && (req.op == qcs_pkg::OP_INSERT) && !is_full;
  assign del_fire   = accept && (req.op == qcs_pkg::OP_DELETE) && !is_empty;
  assign scan_start = accept && (req.op == qcs_pkg::OP_SEARCH) && !is_empty;
  assign rotate     = del_fire || (state == S_SCAN);
  assign scan_last  = (state == S_SCAN) && (scan_cnt == IDX_W'(DEPTH - 1));
  // only the live entries take part in the compare
  assign hit        = (OCC_W'(scan_cnt) < occupancy) && (cell_q[0] == key);

  always_comb begin
    acc_status  = qcs_pkg::ST_DONE;
    acc_removed = '0;
    case (req.op)
      qcs_pkg::OP_INSERT: begin
        if (is_full) begin
          acc_status = qcs_pkg::ST_FULL;
        end
      end
      qcs_pkg::OP_DELETE: begin
        if (is_empty) begin
          acc_status = qcs_pkg::ST_EMPTY;
        end else begin
          acc_removed = cell_q[0];
        end
      end
      qcs_pkg::OP_SEARCH: begin
        if (is_empty) begin
          acc_status = qcs_pkg::ST_EMPTY;
        end
      end
      default: begin
        acc_status = qcs_pkg::ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qcs_pkg::cell_ctrl_t ctrl;

    assign ctrl.shift = rotate;
    assign ctrl.load  = ins_fire && (occupancy[IDX_W-1:0] == IDX_W'(i));

    qcs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (req.value),
      .nbr_data  (cell_q[(i + 1) % DEPTH]),
      .data      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ins_fire) begin
        occupancy <= occupancy + OCC_W'(1);
      end else if (del_fire) begin
        occupancy <= occupancy - OCC_W'(1);
      end
      if ((accept && !scan_start) || scan_last) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (scan_start) begin
        state <= S_SCAN;
      end else if (scan_last) begin
        state <= S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_cnt <= '0;
      found    <= 1'b0;
      key      <= req.value;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + IDX_W'(1);
      found    <= found || hit;
    end
    if (accept && !scan_start) begin
      rsp_status  <= acc_status;
      rsp_removed <= acc_removed;
    end else if (scan_last) begin
      rsp_status  <= (found || hit) ? qcs_pkg::ST_FOUND : qcs_pkg::ST_NOT_FOUND;
      rsp_removed <= '0;
    end
  end

endmodule

@@ hw/rtl/qcs_checker.sv @@
// ----------------------------------------------------------------------------
// qcs_checker
// Port-level checks of the queue core, bound to the top level.
// ----------------------------------------------------------------------------
module qcs_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input qcs_pkg::op_t     req_op,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input qcs_pkg::status_t rsp_status,
  input qcs_pkg::word_t   rsp_removed_value
);

  logic req_xfer;

  assign req_xfer = req_valid && req_ready;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_removed_value))
    else $error("response changed while stalled");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != qcs_pkg::ST_DONE) |-> rsp_removed_value == '0)
    else $error("removed value nonzero on a non-delete response");

  // everything but search answers in the next cycle
  a_quick_rsp: assert property (@(posedge clk) disable iff (rst)
    req_xfer && (req_op != qcs_pkg::OP_SEARCH) |=> rsp_valid)
    else $error("missing single-cycle response");

  a_insert_status: assert property (@(posedge clk) disable iff (rst)
    req_xfer && (req_op == qcs_pkg::OP_INSERT)
      |=> (rsp_status == qcs_pkg::ST_DONE) || (rsp_status == qcs_pkg::ST_FULL))
    else $error("bad insert status");

  a_delete_status: assert property (@(posedge clk) disable iff (rst)
    req_xfer && (req_op == qcs_pkg::OP_DELETE)
      |=> (rsp_status == qcs_pkg::ST_DONE) || (rsp_status == qcs_pkg::ST_EMPTY))
    else $error("bad delete status");

endmodule

bind circular_queue_with_search_core qcs_checker u_qcs_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_op            (req.op),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_removed_value (rsp.removed_value)
);

@@ tb/sv/circular_queue_with_search_core_tb.sv @@
// ----------------------------------------------------------------------------
// circular_queue_with_search_core_tb
// Drives insert, delete, search and no-op requests into the queue core under
// bursty request traffic and a stalling response side. A scoreboard class
// keeps its own ring of words and checks every response in order.
// ----------------------------------------------------------------------------
module circular_queue_with_search_core_tb;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 750;

  typedef struct {
    qcs_pkg::status_t status;
    qcs_pkg::word_t   removed;
  } queue_rsp_t;

  class queue_scoreboard;
    qcs_pkg::word_t ring[DEPTH];
    int unsigned    head = 0;
    int unsigned    tail = 0;
    int unsigned    occupied = 0;
    queue_rsp_t     pending_rsp[$];
    int unsigned    mismatches = 0;

    // oldest-first access to the live entries
    function qcs_pkg::word_t live_word(int unsigned k);
      return ring[(head + k) % DEPTH];
    endfunction

    function void note_request(qcs_pkg::op_t op, qcs_pkg::word_t value);
      queue_rsp_t r;
      r.status  = qcs_pkg::ST_DONE;
      r.removed = '0;
      case (op)
        qcs_pkg::OP_INSERT: begin
          if (occupied == DEPTH) begin
            r.status = qcs_pkg::ST_FULL;
          end else begin
            ring[tail] = value;
            tail = (tail + 1) % DEPTH;
            occupied++;
          end
        end
        qcs_pkg::OP_DELETE: begin
          if (occupied == 0) begin
            r.status = qcs_pkg::ST_EMPTY;
          end else begin
            r.removed = ring[head];
            head = (head + 1) % DEPTH;
            occupied--;
          end
        end
        qcs_pkg::OP_SEARCH: begin
          if (occupied == 0) begin
            r.status = qcs_pkg::ST_EMPTY;
          end else begin
            r.status = qcs_pkg::ST_NOT_FOUND;
            for (int unsigned k = 0; k < occupied; k++) begin
              if (live_word(k) == value) begin
                r.status = qcs_pkg::ST_FOUND;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      pending_rsp.push_back(r);
    endfunction

    function void check_response(qcs_pkg::status_t status, qcs_pkg::word_t removed);
      queue_rsp_t r;
      if (pending_rsp.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: response with nothing pending: status %0d removed %0d",
                   status, removed);
        mismatches++;
        return;
      end
      r = pending_rsp.pop_front();
      if (status !== r.status || removed !== r.removed) begin
        if (mismatches < 10)
          $display("ERROR: status exp %0d got %0d, removed_value exp %0d got %0d",
                   r.status, status, r.removed, removed);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  qcs_req_if req_ch();
  qcs_rsp_if rsp_ch();

  circular_queue_with_search_core #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_scoreboard sb = new;

  int unsigned burst_left = 1;
  int unsigned rsp_taken = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one request and wait for its transaction, then maybe end the burst
  task automatic offer_request(qcs_pkg::op_t op, qcs_pkg::word_t value);
    int unsigned gap;
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, value);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic qcs_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return qcs_pkg::word_t'($urandom);
    endcase
  endfunction

  // response side: changing stall patterns plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) rsp_taken++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!held_once && rsp_taken >= 300) begin
        held_once = 1'b1;
        hold_left = 400;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 100);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.removed_value);
  end

  initial begin
    #2_000_000;
    $display("circular_queue_with_search_core test failed");
    $finish;
  end

  initial begin
    int unsigned    issued;
    int unsigned    phase;
    int unsigned    phase_len;
    int unsigned    r;
    qcs_pkg::op_t   op;
    qcs_pkg::word_t value;

    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = qcs_pkg::OP_NOP;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, no-op, extremes, full queue, tail wrap
    offer_request(qcs_pkg::OP_SEARCH, 32'sd7);
    offer_request(qcs_pkg::OP_DELETE, '0);
    offer_request(qcs_pkg::OP_NOP, 32'sh7fff_ffff);
    offer_request(qcs_pkg::OP_INSERT, 32'sh8000_0000);
    offer_request(qcs_pkg::OP_INSERT, 32'sh7fff_ffff);
    offer_request(qcs_pkg::OP_SEARCH, 32'sh7fff_ffff);
    offer_request(qcs_pkg::OP_SEARCH, 32'sd12345);
    offer_request(qcs_pkg::OP_DELETE, '1);
    for (int i = 0; i < DEPTH - 1; i++)
      offer_request(qcs_pkg::OP_INSERT,
                    (i % 2) ? 32'sh5555_5555 + i : 32'shaaaa_aaaa - i);
    offer_request(qcs_pkg::OP_INSERT, '1);
    offer_request(qcs_pkg::OP_SEARCH, 32'sh7fff_ffff);
    offer_request(qcs_pkg::OP_SEARCH, sb.live_word(DEPTH - 1));
    offer_request(qcs_pkg::OP_DELETE, '0);
    offer_request(qcs_pkg::OP_INSERT, '0);

    // random phases that lean toward filling, draining or neither
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      phase     = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < (phase == 0 ? 60 : phase == 1 ? 20 : 35))
          op = qcs_pkg::OP_INSERT;
        else if (r < (phase == 0 ? 75 : 65))
          op = qcs_pkg::OP_DELETE;
        else if (r < 97)
          op = qcs_pkg::OP_SEARCH;
        else
          op = qcs_pkg::OP_NOP;
        if (op == qcs_pkg::OP_SEARCH && sb.occupied > 0 && $urandom_range(0, 2) != 0)
          value = sb.live_word($urandom_range(0, sb.occupied - 1));
        else
          value = pick_word();
        offer_request(op, value);
        issued++;
      end
    end
    req_ch.valid <= 1'b0;

    while (sb.pending_rsp.size() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
      $display("circular_queue_with_search_core test passed");
    else
      $display("circular_queue_with_search_core test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/qcs_pkg.sv
hw/rtl/qcs_if.sv
hw/rtl/qcs_cell.sv
hw/rtl/circular_queue_with_search_core.sv
hw/rtl/qcs_checker.sv
tb/sv/circular_queue_with_search_core_tb.sv
